FILE: design/adf_pkg.sv
package adf_pkg;

	localparam int ADF_MAX_REPORT_BYTES = 255;

	localparam logic [1:0] PROC_NONE    = 2'd0;
	localparam logic [1:0] PROC_LIMITED = 2'd1;
	localparam logic [1:0] PROC_GENERAL = 2'd2;

	localparam logic [7:0] AD_TYPE_FLAGS = 8'h01;
	localparam logic [7:0] LIMITED_BIT   = 8'h01;
	localparam logic [7:0] GENERAL_BIT   = 8'h02;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] report_length;
		logic       first_byte;
	} item_t;

	typedef struct packed {
		logic       accept;
		logic       flags_found;
		logic [7:0] flags_value;
	} result_t;

	function automatic result_t verdict(input logic [1:0] proc, input logic seen,
		input logic [7:0] fbyte);
		result_t r;
		r.flags_found = seen;
		r.flags_value = seen ? fbyte : 8'd0;
		case (proc)
			PROC_NONE:    r.accept = 1'b1;
			PROC_LIMITED: r.accept = seen && ((fbyte & LIMITED_BIT) != 8'd0);
			PROC_GENERAL: r.accept = seen && ((fbyte & (LIMITED_BIT | GENERAL_BIT)) != 8'd0);
			default:      r.accept = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: design/adf_in_stage.sv
module adf_in_stage
	import adf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: design/adf_walk.sv
module adf_walk
	import adf_pkg::*;
#(
	parameter int MAX_REPORT_BYTES = ADF_MAX_REPORT_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       valid_s1,
	input  item_t      item_s1,
	input  logic       out_free,
	output logic       take,
	output logic       res_valid,
	output result_t    res
);

	localparam logic [7:0] MaxLen = 8'(MAX_REPORT_BYTES);

	logic [1:0] proc_q;
	logic [7:0] pos_q;
	logic [8:0] start_q;
	logic [7:0] slen_q;
	logic       stopped_q;
	logic       fseen_q;
	logic [7:0] fbyte_q;
	logic       inflags_q;

	logic [7:0] pos_d;
	logic [8:0] start_d;
	logic [7:0] slen_d;
	logic       stopped_d;
	logic       fseen_d;
	logic [7:0] fbyte_d;
	logic       inflags_d;
	logic [7:0] len;
	logic [7:0] b;
	logic       res_gen;

	always_comb begin
		len = (item_s1.report_length > MaxLen) ? MaxLen : item_s1.report_length;
		b = item_s1.data_byte;
		if (item_s1.first_byte) begin
			pos_d = '0; start_d = '0; slen_d = '0; stopped_d = 1'b0;
			fseen_d = 1'b0; fbyte_d = '0; inflags_d = 1'b0;
		end else begin
			pos_d = pos_q; start_d = start_q; slen_d = slen_q; stopped_d = stopped_q;
			fseen_d = fseen_q; fbyte_d = fbyte_q; inflags_d = inflags_q;
		end
		res_gen = 1'b0;
		if (len == 8'd0) begin
			pos_d = '0; start_d = '0; slen_d = '0; stopped_d = 1'b0;
			fseen_d = 1'b0; fbyte_d = '0; inflags_d = 1'b0;
			res_gen = 1'b1;
		end else if (pos_d < len) begin
			if (!stopped_d) begin
				if (inflags_d) begin
					if ({2'b0, pos_d} == {1'b0, start_d} + 10'd2) begin
						fbyte_d = b;
						fseen_d = 1'b1;
						inflags_d = 1'b0;
						stopped_d = 1'b1;
					end
				end else if ({1'b0, pos_d} == start_d) begin
					if (b == 8'd0 ||
						{1'b0, start_d} + 10'd1 + {2'b0, b} > {2'b0, len}) begin
						stopped_d = 1'b1;
					end else begin
						slen_d = b;
					end
				end else if ({2'b0, pos_d} == {1'b0, start_d} + 10'd1) begin
					if (b == AD_TYPE_FLAGS) begin
						if (slen_d == 8'd1) begin
							fbyte_d = '0;
							fseen_d = 1'b1;
							stopped_d = 1'b1;
						end else begin
							inflags_d = 1'b1;
						end
					end else begin
						start_d = 9'({1'b0, start_d} + 10'd1 + {2'b0, slen_d});
					end
				end
			end
			res_gen = ({1'b0, pos_d} + 9'd1 == {1'b0, len});
			pos_d = pos_d + 8'd1;
		end
		res = verdict(proc_q, fseen_d, fbyte_d);
	end

	assign take = valid_s1 && (!res_gen || out_free);
	assign res_valid = take && res_gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_q    <= PROC_NONE;
			pos_q     <= '0;
			start_q   <= '0;
			slen_q    <= '0;
			stopped_q <= 1'b0;
			fseen_q   <= 1'b0;
			fbyte_q   <= '0;
			inflags_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				proc_q <= cfg_wdata;
			end
			if (take) begin
				pos_q     <= pos_d;
				start_q   <= start_d;
				slen_q    <= slen_d;
				stopped_q <= stopped_d;
				fseen_q   <= fseen_d;
				fbyte_q   <= fbyte_d;
				inflags_q <= inflags_d;
			end
		end
	end

	// Found flags always end the walk, and a pending flags value means it is still running.
	a_seen_stops: assert property (@(posedge clk) disable iff (!arst_n)
		fseen_q |-> stopped_q) else $error("flags seen while walk still running");
	a_pending_running: assert property (@(posedge clk) disable iff (!arst_n)
		inflags_q |-> !stopped_q) else $error("flags value pending after walk ended");
	a_no_flags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!fseen_q |-> fbyte_q == 8'd0) else $error("flags byte set without flags");
	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free) else $error("result word produced with no room");

endmodule

FILE: design/adf_out_stage.sv
module adf_out_stage
	import adf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

FILE: design/advertising_discovery_filter_top.sv
// A result word is registered and becomes valid in the cycle after the byte that completes the report is taken.
// Throughput: one byte per cycle while the input is not stalled; the walk state updates in the single compare stage.
// Bytes that do not end a report keep flowing while a result word waits downstream.
// A byte that ends a report waits in the input register until the result register is free.
// Reset clears the procedure to none, the walk state and both valid flags.
module advertising_discovery_filter_top
	import adf_pkg::*;
#(
	parameter int MAX_REPORT_BYTES = ADF_MAX_REPORT_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic [7:0] report_length,
	input  logic       first_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accept,
	output logic       flags_found,
	output logic [7:0] flags_value
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    take;
	logic    res_valid;
	logic    out_free;
	result_t res;
	result_t out_res;

	assign in_item.data_byte     = data_byte;
	assign in_item.report_length = report_length;
	assign in_item.first_byte    = first_byte;

	adf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	adf_walk #(
		.MAX_REPORT_BYTES (MAX_REPORT_BYTES)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	adf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign accept      = out_res.accept;
	assign flags_found = out_res.flags_found;
	assign flags_value = out_res.flags_value;

endmodule
